FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/dmcc_pkg.sv
`default_nettype none

package dmcc_pkg;

  localparam int unsigned NUM_SLOTS   = 64;
  localparam int unsigned SLOT_BITS   = $clog2(NUM_SLOTS);
  localparam int unsigned SLOT_BYTES  = 128;
  localparam int unsigned INDEX_SHIFT = 6;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP      = 2'd0,
    OP_OUTCOME     = 2'd1,
    OP_STAT_CLEAR  = 2'd2,
    OP_RESERVED    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CACHE_BOUND = 2'd0,
    CFG_REGION_BASE = 2'd1,
    CFG_REGION_SIZE = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                 hit;
    logic [SLOT_BITS-1:0] slot;
    logic                 fetch_needed;
    logic [ADDR_W-1:0]    fetch_address;
    logic [LEN_W-1:0]     fetch_length;
    logic                 zero_fill;
    logic                 unbound;
    logic [ADDR_W-1:0]    fetch_count;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/dmcc_ifs.sv
`default_nettype none

interface dmcc_req_if;
  logic                           valid;
  logic                           ready;
  logic [dmcc_pkg::OP_W-1:0]      operation;
  logic [dmcc_pkg::ADDR_W-1:0]    offset;
  logic                           read_ok;

  modport source (output valid, operation, offset, read_ok, input ready);
  modport sink   (input valid, operation, offset, read_ok, output ready);
endinterface

interface dmcc_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [dmcc_pkg::SLOT_BITS-1:0] slot;
  logic                           fetch_needed;
  logic [dmcc_pkg::ADDR_W-1:0]    fetch_address;
  logic [dmcc_pkg::LEN_W-1:0]     fetch_length;
  logic                           zero_fill;
  logic                           unbound;
  logic [dmcc_pkg::ADDR_W-1:0]    fetch_count;

  modport source (output valid, hit, slot, fetch_needed, fetch_address, fetch_length,
                  zero_fill, unbound, fetch_count, input ready);
  modport sink   (input valid, hit, slot, fetch_needed, fetch_address, fetch_length,
                  zero_fill, unbound, fetch_count, output ready);
endinterface

interface dmcc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dmcc_pkg::CFG_IDX_W-1:0]   index;
  logic [dmcc_pkg::ADDR_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dmcc_ram.sv
`default_nettype none

module dmcc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/direct_mapped_column_cache_control.sv
// channel  dir  handshake     payload
// cfg      in   valid/ready   index, data (register write, always ready)
// req      in   valid/ready   operation, offset, read_ok
// rsp      out  valid/ready   hit, slot, fetch_needed, fetch_address, fetch_length,
//                             zero_fill, unbound, fetch_count
//
// each item first reads the tag memory, then compares, writes back and loads
// the output register.
// req is taken only in idle; a result waiting in the output register stalls
// the compare step until rsp takes it.
// reset is synchronous; per-slot valid flops clear at once, so no clearing pass.

`include "assert_macros.svh"

`default_nettype none

module direct_mapped_column_cache_control (
  input  wire logic clk,
  input  wire logic rst,
  dmcc_cfg_if.sink  cfg,
  dmcc_req_if.sink  req,
  dmcc_rsp_if.source rsp
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                           state;
  logic                             cache_bound;
  logic [dmcc_pkg::ADDR_W-1:0]      region_base;
  logic [dmcc_pkg::ADDR_W-1:0]      region_size;

  dmcc_pkg::op_t                    item_op;
  logic [dmcc_pkg::ADDR_W-1:0]      item_offset;
  logic                             item_ok;

  logic [dmcc_pkg::NUM_SLOTS-1:0]   slot_valid;
  logic [dmcc_pkg::ADDR_W-1:0]      fetch_counter;
  logic [dmcc_pkg::ADDR_W-1:0]      fetch_counter_next;
  logic [dmcc_pkg::SLOT_BITS-1:0]   pending_slot;
  logic [dmcc_pkg::SLOT_BITS-1:0]   pending_slot_next;

  logic                             rsp_valid;
  dmcc_pkg::rsp_t                   rsp_q;
  dmcc_pkg::rsp_t                   rsp_next;

  logic                             req_fire;
  logic                             exec_fire;
  logic [dmcc_pkg::SLOT_BITS-1:0]   item_slot;
  logic [dmcc_pkg::ADDR_W-1:0]      tag_rdata;
  logic                             tag_we;
  logic                             tag_hit;
  logic [dmcc_pkg::ADDR_W-1:0]      room;
  logic [dmcc_pkg::LEN_W-1:0]       clamp_len;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign exec_fire = (state == S_EXEC) && (!rsp_valid || rsp.ready);

  assign item_slot = item_offset[dmcc_pkg::INDEX_SHIFT +: dmcc_pkg::SLOT_BITS];

  dmcc_ram #(
    .WIDTH (dmcc_pkg::ADDR_W),
    .DEPTH (dmcc_pkg::NUM_SLOTS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (item_slot),
    .wdata (item_offset),
    .re    (req_fire),
    .raddr (req.offset[dmcc_pkg::INDEX_SHIFT +: dmcc_pkg::SLOT_BITS]),
    .rdata (tag_rdata)
  );

  assign tag_hit = slot_valid[item_slot] && (tag_rdata == item_offset);
  assign room    = region_size - item_offset;

  always_comb begin
    if (item_offset >= region_size) begin
      clamp_len = '0;
    end else if (room < dmcc_pkg::ADDR_W'(dmcc_pkg::SLOT_BYTES)) begin
      clamp_len = room[dmcc_pkg::LEN_W-1:0];
    end else begin
      clamp_len = dmcc_pkg::LEN_W'(dmcc_pkg::SLOT_BYTES);
    end
  end

  always_comb begin
    rsp_next           = '0;
    tag_we             = 1'b0;
    fetch_counter_next = fetch_counter;
    pending_slot_next  = pending_slot;
    case (item_op)
      dmcc_pkg::OP_LOOKUP: begin
        if (!cache_bound) begin
          rsp_next.unbound = 1'b1;
        end else begin
          rsp_next.slot = item_slot;
          if (tag_hit) begin
            rsp_next.hit = 1'b1;
          end else begin
            tag_we                 = exec_fire;
            pending_slot_next      = item_slot;
            rsp_next.fetch_needed  = 1'b1;
            rsp_next.fetch_address = region_base + item_offset;
            rsp_next.fetch_length  = clamp_len;
          end
        end
      end
      dmcc_pkg::OP_OUTCOME: begin
        rsp_next.slot = pending_slot;
        if (item_ok) begin
          fetch_counter_next = fetch_counter + 1'b1;
        end else begin
          rsp_next.zero_fill = 1'b1;
        end
      end
      dmcc_pkg::OP_STAT_CLEAR: begin
        fetch_counter_next = '0;
      end
      default: begin
      end
    endcase
    rsp_next.fetch_count = fetch_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cache_bound   <= 1'b0;
      region_base   <= '0;
      region_size   <= '0;
      slot_valid    <= '0;
      fetch_counter <= '0;
      pending_slot  <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (dmcc_pkg::cfg_idx_t'(cfg.index))
          dmcc_pkg::CFG_CACHE_BOUND: cache_bound <= cfg.data[0];
          dmcc_pkg::CFG_REGION_BASE: region_base <= cfg.data;
          dmcc_pkg::CFG_REGION_SIZE: region_size <= cfg.data;
          default: begin
          end
        endcase
      end
      // a new result may replace the one leaving in the same cycle
      if (exec_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            state         <= S_IDLE;
            fetch_counter <= fetch_counter_next;
            pending_slot  <= pending_slot_next;
            if (tag_we) begin
              slot_valid[item_slot] <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item and result payload, no reset needed
  always_ff @(posedge clk) begin
    if (req_fire) begin
      item_op     <= dmcc_pkg::op_t'(req.operation);
      item_offset <= req.offset;
      item_ok     <= req.read_ok;
    end
    if (exec_fire) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.hit           = rsp_q.hit;
  assign rsp.slot          = rsp_q.slot;
  assign rsp.fetch_needed  = rsp_q.fetch_needed;
  assign rsp.fetch_address = rsp_q.fetch_address;
  assign rsp.fetch_length  = rsp_q.fetch_length;
  assign rsp.zero_fill     = rsp_q.zero_fill;
  assign rsp.unbound       = rsp_q.unbound;
  assign rsp.fetch_count   = rsp_q.fetch_count;

  `ASSERT_NEXT(a_accept_to_exec, clk, rst, req_fire, state == S_EXEC)
  `ASSERT_SAME(a_hit_excl, clk, rst, rsp_valid && rsp_q.hit,
               !rsp_q.fetch_needed && !rsp_q.unbound && !rsp_q.zero_fill)
  `ASSERT_SAME(a_miss_pending, clk, rst, rsp_valid && rsp_q.fetch_needed,
               pending_slot == rsp_q.slot && slot_valid[rsp_q.slot])
  `ASSERT_SAME(a_exec_no_accept, clk, rst, state == S_EXEC, !req.ready)

endmodule

`default_nettype wire
